[src/vta_pkg.sv]
// ----------------------------------------------------------------------------
// vta_pkg: shared types and constants of the vectored thrust allocator
// angle and pulse fixed-point constants, register map, controller states,
// controller command bundle and the quarter-wave sine table builder
// ----------------------------------------------------------------------------
package vta_pkg;

    localparam int ANGLE_FRAC_BITS  = 4;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int ANG_90           = 90 << ANGLE_FRAC_BITS;
    localparam int ANG_180          = 180 << ANGLE_FRAC_BITS;
    localparam int ANGLE_W          = 12;
    localparam int QADDR_W          = $clog2(ANG_90 + 1);
    localparam int PULSE_SHIFT      = 35;
    localparam int PULSE_W          = 16;
    localparam int GAIN_W           = 17;
    localparam int GAIN_ONE         = 65536;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q15     = 64'd32768;

    localparam logic [ANGLE_W-1:0] ANG_90_C  = ANGLE_W'(ANG_90);
    localparam logic [ANGLE_W-1:0] ANG_180_C = ANGLE_W'(ANG_180);

    // register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_NEUTRAL_WIDTH   = 3'd0,
        REG_WIDTH_FLOOR     = 3'd1,
        REG_WIDTH_CEIL      = 3'd2,
        REG_MAX_ANGLE_STEP  = 3'd3,
        REG_CORRECTION_GAIN = 3'd4
    } vta_reg_t;

    typedef enum logic {
        CMD_COMPUTE     = 1'b0,
        CMD_RESET_ANGLE = 1'b1
    } vta_command_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_S,
        ST_RD_C,
        ST_MUL_K,
        ST_SUM_M,
        ST_MUL_P,
        ST_ADD,
        ST_CLAMP,
        ST_DONE
    } vta_state_t;

    typedef struct packed {
        logic load_item;
        logic reset_angle;
        logic rd_c;
        logic capture_sin;
        logic mul_k;
        logic sum_m;
        logic mul_p;
        logic add_l;
        logic clamp_l;
        logic load_out;
    } vta_cmd_t;

    typedef logic [PULSE_W-1:0] sine_table_t [0:ANG_90];

    // sine indexed directly by quarter angle in fixed-point degrees
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] idx;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] r;
        for (int q = 0; q <= ANG_90; q++) begin
            idx = (64'(q) * 64'(SINE_TABLE_DEPTH) + 64'(ANG_90 / 2)) / ANG_90;
            if (idx > 64'(SINE_TABLE_DEPTH)) begin
                idx = 64'(SINE_TABLE_DEPTH);
            end
            x    = (HALF_PI_Q30 * idx + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            r = ($unsigned(sum) + (64'd1 << 14)) >> 15;
            if (r > ONE_Q15) begin
                r = ONE_Q15;
            end
            tbl[q] = r[PULSE_W-1:0];
        end
        return tbl;
    endfunction

endpackage

[src/vectored_thrust_allocator.sv]
// ----------------------------------------------------------------------------
// vectored_thrust_allocator: differential thrust mixer with slew-limited angle
// a compute transaction steps through RD_S, RD_C, MUL_K, SUM_M, MUL_P, ADD,
// CLAMP and DONE, set by the shared multiplier and the single sine table port;
// no new one is taken before IDLE; a reset transaction is handled in IDLE
// reset: synchronous active-low aresetn restores register defaults and the
// 90 degree angle, and empties the output register
// ----------------------------------------------------------------------------
module vectored_thrust_allocator
    import vta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [12:0] s_target_angle,
    input  logic signed [15:0] s_pid_output,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_thrust_l,
    output logic [15:0]        m_thrust_r,
    output logic [11:0]        m_applied_angle
);

    logic [PULSE_W-1:0] neutral_width_reg;
    logic [PULSE_W-1:0] width_floor_reg;
    logic [PULSE_W-1:0] width_ceil_reg;
    logic [ANGLE_W-1:0] max_angle_step_reg;
    logic [GAIN_W-1:0]  correction_gain_reg;
    logic               wr_en;
    vta_reg_t           reg_idx;
    vta_cmd_t           cmd;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = vta_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neutral_width_reg   <= 16'd1500;
            width_floor_reg     <= 16'd1000;
            width_ceil_reg      <= 16'd2000;
            max_angle_step_reg  <= 12'd16;
            correction_gain_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEUTRAL_WIDTH:   neutral_width_reg   <= pwdata[PULSE_W-1:0];
                REG_WIDTH_FLOOR:     width_floor_reg     <= pwdata[PULSE_W-1:0];
                REG_WIDTH_CEIL:      width_ceil_reg      <= pwdata[PULSE_W-1:0];
                REG_MAX_ANGLE_STEP:  max_angle_step_reg  <= pwdata[ANGLE_W-1:0];
                REG_CORRECTION_GAIN: correction_gain_reg <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEUTRAL_WIDTH:   prdata = 32'(neutral_width_reg);
            REG_WIDTH_FLOOR:     prdata = 32'(width_floor_reg);
            REG_WIDTH_CEIL:      prdata = 32'(width_ceil_reg);
            REG_MAX_ANGLE_STEP:  prdata = 32'(max_angle_step_reg);
            REG_CORRECTION_GAIN: prdata = 32'(correction_gain_reg);
            default:             prdata = '0;
        endcase
    end

    vta_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    vta_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_target_angle  (s_target_angle),
        .s_pid_output    (s_pid_output),
        .neutral_width   (neutral_width_reg),
        .width_floor     (width_floor_reg),
        .width_ceil      (width_ceil_reg),
        .max_angle_step  (max_angle_step_reg),
        .correction_gain (correction_gain_reg),
        .m_thrust_l      (m_thrust_l),
        .m_thrust_r      (m_thrust_r),
        .m_applied_angle (m_applied_angle)
    );

endmodule

[src/vta_sine_rom.sv]
// ----------------------------------------------------------------------------
// vta_sine_rom: quarter-wave sine table
// single read port, registered read data, addressed by quarter angle
// ----------------------------------------------------------------------------
module vta_sine_rom
    import vta_pkg::*;
(
    input  logic               aclk,
    input  logic [QADDR_W-1:0] rd_addr,
    output logic [PULSE_W-1:0] rd_data
);

    localparam sine_table_t SINE_ROM = build_sine_table();

    logic [PULSE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= SINE_ROM[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/vta_ctrl.sv]
// ----------------------------------------------------------------------------
// vta_ctrl: sequencing controller
// steps one compute transaction through table reads, the shared multiplier,
// the pulse sums and clamps, and owns the input ready and the output valid
// ----------------------------------------------------------------------------
module vta_ctrl
    import vta_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_command,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output vta_cmd_t cmd
);

    vta_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_RESET_ANGLE) begin
                        cmd.reset_angle = 1'b1;
                    end else begin
                        cmd.load_item = 1'b1;
                        state_next    = ST_RD_S;
                    end
                end
            end
            ST_RD_S: begin
                state_next = ST_RD_C;
            end
            ST_RD_C: begin
                cmd.rd_c        = 1'b1;
                cmd.capture_sin = 1'b1;
                state_next      = ST_MUL_K;
            end
            ST_MUL_K: begin
                cmd.mul_k  = 1'b1;
                state_next = ST_SUM_M;
            end
            ST_SUM_M: begin
                cmd.sum_m  = 1'b1;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.mul_p  = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_l  = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp_l = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[src/vta_datapath.sv]
// ----------------------------------------------------------------------------
// vta_datapath: angle slew, sine lookup and pulse mixing datapath
// holds the slewed angle, one shared signed multiplier, the pulse sum
// register with clamp and rounding, and the result payload registers
// ----------------------------------------------------------------------------
module vta_datapath
    import vta_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  vta_cmd_t                 cmd,
    input  logic signed [12:0]       s_target_angle,
    input  logic signed [15:0]       s_pid_output,
    input  logic [PULSE_W-1:0]       neutral_width,
    input  logic [PULSE_W-1:0]       width_floor,
    input  logic [PULSE_W-1:0]       width_ceil,
    input  logic [ANGLE_W-1:0]       max_angle_step,
    input  logic [GAIN_W-1:0]        correction_gain,
    output logic [PULSE_W-1:0]       m_thrust_l,
    output logic [PULSE_W-1:0]       m_thrust_r,
    output logic [ANGLE_W-1:0]       m_applied_angle
);

    logic [ANGLE_W-1:0]        angle_reg, angle_next;
    logic signed [15:0]        pid_reg;
    logic [PULSE_W-1:0]        sin_reg;
    logic signed [52:0]        prod_reg;
    logic signed [33:0]        m_reg;
    logic signed [53:0]        v_reg;
    logic [PULSE_W-1:0]        left_reg;
    logic [PULSE_W-1:0]        out_left_reg;
    logic [PULSE_W-1:0]        out_right_reg;
    logic [ANGLE_W-1:0]        out_angle_reg;

    logic [ANGLE_W-1:0]        tgt_clamped;
    logic signed [13:0]        diff;
    logic signed [13:0]        step;
    logic signed [14:0]        slew_sum;
    logic [QADDR_W-1:0]        s_idx;
    logic [QADDR_W-1:0]        c_idx;
    logic [QADDR_W-1:0]        rom_addr;
    logic [PULSE_W-1:0]        rom_q;
    logic                      upper_half;
    logic signed [17:0]        c_val;
    logic [GAIN_W-1:0]         k_sat;
    logic signed [34:0]        op_a;
    logic signed [17:0]        op_b;
    logic signed [53:0]        base_ext;
    logic signed [53:0]        delta_ext;

    function automatic logic [PULSE_W-1:0] clamp_round(
        input logic signed [53:0]  v,
        input logic [PULSE_W-1:0]  lo,
        input logic [PULSE_W-1:0]  hi
    );
        logic signed [53:0] lo_ext;
        logic signed [53:0] hi_ext;
        logic signed [53:0] rnd;
        logic [PULSE_W-1:0] res;
        lo_ext = $signed({3'b000, lo, 35'd0});
        hi_ext = $signed({3'b000, hi, 35'd0});
        rnd    = v + $signed(54'd1 << (PULSE_SHIFT - 1));
        if (v < lo_ext) begin
            res = (lo > hi) ? hi : lo;
        end else if (v > hi_ext) begin
            res = hi;
        end else begin
            res = rnd[PULSE_SHIFT+PULSE_W-1:PULSE_SHIFT];
        end
        return res;
    endfunction

    // target clamp and slew
    always_comb begin
        if (s_target_angle < 13'sd0) begin
            tgt_clamped = '0;
        end else if (s_target_angle > $signed({1'b0, ANG_180_C})) begin
            tgt_clamped = ANG_180_C;
        end else begin
            tgt_clamped = s_target_angle[ANGLE_W-1:0];
        end
        diff = $signed({2'b00, tgt_clamped}) - $signed({2'b00, angle_reg});
        step = $signed({2'b00, max_angle_step});
        priority if (diff > step) begin
            slew_sum = $signed({3'b000, angle_reg}) + $signed({3'b000, max_angle_step});
        end else if (diff < -step) begin
            slew_sum = $signed({3'b000, angle_reg}) - $signed({3'b000, max_angle_step});
        end else begin
            slew_sum = $signed({3'b000, tgt_clamped});
        end
        if (slew_sum < 15'sd0) begin
            angle_next = '0;
        end else if (slew_sum > $signed({3'b000, ANG_180_C})) begin
            angle_next = ANG_180_C;
        end else begin
            angle_next = slew_sum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= ANG_90_C;
        end else if (cmd.reset_angle) begin
            angle_reg <= ANG_90_C;
        end else if (cmd.load_item) begin
            angle_reg <= angle_next;
        end
    end

    // table addressing: sine folds about 90 degrees, cosine mirrors
    always_comb begin
        upper_half = (angle_reg > ANG_90_C);
        if (upper_half) begin
            s_idx = QADDR_W'(ANG_180_C - angle_reg);
            c_idx = QADDR_W'(angle_reg - ANG_90_C);
        end else begin
            s_idx = QADDR_W'(angle_reg);
            c_idx = QADDR_W'(ANG_90_C - angle_reg);
        end
        rom_addr = cmd.rd_c ? c_idx : s_idx;
    end

    vta_sine_rom u_sine_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_q)
    );

    // shared multiplier operands
    always_comb begin
        c_val = upper_half ? $signed({2'b00, rom_q}) : -$signed({2'b00, rom_q});
        k_sat = (correction_gain > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : correction_gain;
        if (cmd.mul_p) begin
            op_a = 35'(m_reg);
            op_b = 18'(pid_reg);
        end else begin
            op_a = 35'(c_val);
            op_b = $signed({1'b0, k_sat});
        end
        base_ext  = $signed({3'b000, neutral_width, 35'd0});
        delta_ext = 54'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            pid_reg <= s_pid_output;
        end
        if (cmd.capture_sin) begin
            sin_reg <= rom_q;
        end
        if (cmd.mul_k || cmd.mul_p) begin
            prod_reg <= 53'(op_a * op_b);
        end
        if (cmd.sum_m) begin
            m_reg <= $signed({2'b00, sin_reg, 16'd0}) + prod_reg[33:0];
        end
        if (cmd.add_l) begin
            v_reg <= base_ext + delta_ext;
        end
        if (cmd.clamp_l) begin
            left_reg <= clamp_round(v_reg, width_floor, width_ceil);
            v_reg    <= base_ext - delta_ext;
        end
        if (cmd.load_out) begin
            out_left_reg  <= left_reg;
            out_right_reg <= clamp_round(v_reg, width_floor, width_ceil);
            out_angle_reg <= angle_reg;
        end
    end

    assign m_thrust_l      = out_left_reg;
    assign m_thrust_r      = out_right_reg;
    assign m_applied_angle = out_angle_reg;

endmodule

[sim/vectored_thrust_allocator_tb.sv]
// ----------------------------------------------------------------------------
// vectored_thrust_allocator_tb: self-checking bench for the thrust allocator
// a directed table with hand-worked pulses, then phases of random compute and
// angle-reset transactions under different register settings and idle
// patterns; results not hand-worked are scored against an in-bench mixer model
// ----------------------------------------------------------------------------
module vectored_thrust_allocator_tb
    import vta_pkg::*;
();

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_CYCLES     = 300;
    localparam int MAX_GAP         = 40;

    typedef struct packed {
        logic [PULSE_W-1:0] left;
        logic [PULSE_W-1:0] right;
        logic [ANGLE_W-1:0] angle;
    } thrust_result_t;

    typedef struct {
        vta_command_t       cmd;
        logic signed [12:0] target;
        logic signed [15:0] pid;
        bit                 known;
        thrust_result_t     result;
    } thrust_vector_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic signed [12:0] s_target_angle;
    logic signed [15:0] s_pid_output;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_thrust_l;
    logic [15:0]        m_thrust_r;
    logic [11:0]        m_applied_angle;

    // register mirror and slewed angle
    logic [15:0]        neutral_width_r;
    logic [15:0]        width_floor_r;
    logic [15:0]        width_ceil_r;
    logic [11:0]        angle_step_r;
    logic [16:0]        gain_r;
    logic [11:0]        slew_angle;

    int unsigned        sine_q15 [0:SINE_TABLE_DEPTH];
    thrust_result_t     pulse_queue [$];
    int                 error_count     = 0;
    int                 sender_idle_pct = 0;
    int                 stall_pct       = 0;
    int                 hold_request    = 0;

    // default registers: neutral 1500, limits 1000..2000, step 16, gain 0
    thrust_vector_t directed_rows [0:16] = '{
        '{CMD_COMPUTE,      1440,      0, 1, '{1500, 1500, 1440}},
        '{CMD_COMPUTE,      1440,  32767, 1, '{2000, 1000, 1440}},
        '{CMD_COMPUTE,      1440, -32768, 1, '{1000, 2000, 1440}},
        '{CMD_COMPUTE,      1440,      8, 1, '{1501, 1500, 1440}},  // exact half
        '{CMD_COMPUTE,      1440,     -8, 1, '{1500, 1501, 1440}},
        '{CMD_COMPUTE,      4095,      0, 1, '{1500, 1500, 1456}},  // target above 180
        '{CMD_COMPUTE,     -4096,      0, 1, '{1500, 1500, 1440}},  // target below 0
        '{CMD_COMPUTE,      2880,     16, 0, '{0, 0, 0}},
        '{CMD_COMPUTE,      2880,   4000, 0, '{0, 0, 0}},
        '{CMD_RESET_ANGLE,    -1,     -1, 0, '{0, 0, 0}},
        '{CMD_COMPUTE,      1440,      0, 1, '{1500, 1500, 1440}},
        '{CMD_COMPUTE,         0,  -4000, 0, '{0, 0, 0}},
        '{CMD_COMPUTE,         0,  12345, 0, '{0, 0, 0}},
        '{CMD_COMPUTE,      1450,      1, 0, '{0, 0, 0}},
        '{CMD_RESET_ANGLE,     0,      0, 0, '{0, 0, 0}},
        '{CMD_COMPUTE,      1455,     -1, 0, '{0, 0, 0}},
        '{CMD_COMPUTE,      2000,  32767, 0, '{0, 0, 0}}
    };

    vectored_thrust_allocator DUT (.*);

    always #2 aclk = ~aclk;

    function automatic void build_sine_rom();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * i + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = ($unsigned(sum) + 64'd16384) >> 15;
            if (r > ONE_Q15) begin
                r = ONE_Q15;
            end
            sine_q15[i] = 32'(r);
        end
    endfunction

    function automatic longint quarter_sine_at(input longint q);
        longint idx;
        if (q < 0) begin
            q = 0;
        end
        if (q > ANG_90) begin
            q = ANG_90;
        end
        idx = (q * SINE_TABLE_DEPTH + ANG_90 / 2) / ANG_90;
        if (idx > SINE_TABLE_DEPTH) begin
            idx = SINE_TABLE_DEPTH;
        end
        return sine_q15[idx];
    endfunction

    function automatic logic [PULSE_W-1:0] pulse_clamp_round(input longint v);
        longint          lo;
        longint          hi;
        longint unsigned u;
        lo = width_floor_r;
        lo = lo <<< PULSE_SHIFT;
        hi = width_ceil_r;
        hi = hi <<< PULSE_SHIFT;
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        u = v;
        u = (u + (64'd1 << (PULSE_SHIFT - 1))) >> PULSE_SHIFT;
        return u[PULSE_W-1:0];
    endfunction

    // advances the slewed angle and returns 1 when the transaction yields pulses
    function automatic bit mix_thrust(input vta_command_t cmd, input logic signed [12:0] tgt,
                                      input logic signed [15:0] pid,
                                      output thrust_result_t res);
        longint target;
        longint angle;
        longint stepv;
        longint pidv;
        longint s;
        longint c;
        longint k;
        longint delta;
        longint base;
        res = '0;
        if (cmd == CMD_RESET_ANGLE) begin
            slew_angle = ANG_90_C;
            return 1'b0;
        end
        target = tgt;
        pidv   = pid;
        angle  = slew_angle;
        stepv  = angle_step_r;
        if (target < 0) begin
            target = 0;
        end
        if (target > ANG_180) begin
            target = ANG_180;
        end
        if (target - angle > stepv) begin
            angle = angle + stepv;
        end else if (target - angle < -stepv) begin
            angle = angle - stepv;
        end else begin
            angle = target;
        end
        if (angle < 0) begin
            angle = 0;
        end
        if (angle > ANG_180) begin
            angle = ANG_180;
        end
        slew_angle = angle[ANGLE_W-1:0];
        // s = sin(theta), c = -cos(theta)
        if (angle <= ANG_90) begin
            s = quarter_sine_at(angle);
            c = -quarter_sine_at(ANG_90 - angle);
        end else begin
            s = quarter_sine_at(ANG_180 - angle);
            c = quarter_sine_at(angle - ANG_90);
        end
        k     = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;
        delta = pidv * s * 65536 + pidv * c * k;
        base  = neutral_width_r;
        base  = base <<< PULSE_SHIFT;
        res.left  = pulse_clamp_round(base + delta);
        res.right = pulse_clamp_round(base - delta);
        res.angle = angle[ANGLE_W-1:0];
        return 1'b1;
    endfunction

    task automatic program_reg(input vta_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_NEUTRAL_WIDTH:   neutral_width_r = value[15:0];
            REG_WIDTH_FLOOR:     width_floor_r   = value[15:0];
            REG_WIDTH_CEIL:      width_ceil_r    = value[15:0];
            REG_MAX_ANGLE_STEP:  angle_step_r    = value[11:0];
            REG_CORRECTION_GAIN: gain_r          = value[16:0];
            default: ;
        endcase
    endtask

    task automatic send_thrust_cmd(input vta_command_t cmd, input logic signed [12:0] tgt,
                                   input logic signed [15:0] pid, input bit known,
                                   input thrust_result_t known_result);
        thrust_result_t predicted;
        int             gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_target_angle <= tgt;
        s_pid_output   <= pid;
        do @(posedge aclk); while (!s_ready);
        if (mix_thrust(cmd, tgt, pid, predicted)) begin
            pulse_queue.push_back(known ? known_result : predicted);
        end
    endtask

    task automatic send_random_cmd();
        vta_command_t       cmd;
        logic signed [12:0] tgt;
        logic signed [15:0] pid;
        cmd = ($urandom_range(99) < 6) ? CMD_RESET_ANGLE : CMD_COMPUTE;
        case ($urandom_range(9))
            0, 1:    tgt = 13'($urandom);
            2:       tgt = ($urandom_range(1) == 1) ? 13'sd0 : 13'sd2880;
            default: tgt = 13'($urandom_range(ANG_180));
        endcase
        case ($urandom_range(3))
            0: begin
                pid = 16'($urandom_range(255));
                if ($urandom_range(1) == 1) begin
                    pid = -pid;
                end
            end
            1:       pid = ($urandom_range(1) == 1) ? 16'sh7fff : 16'sh8000;
            default: pid = 16'($urandom);
        endcase
        send_thrust_cmd(cmd, tgt, pid, 1'b0, '0);
    endtask

    task automatic wait_for_results();
        while (pulse_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // sender and register programming
    initial begin
        logic [31:0] settings [5];
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_command       = 1'b0;
        s_target_angle  = '0;
        s_pid_output    = '0;
        neutral_width_r = 16'd1500;
        width_floor_r   = 16'd1000;
        width_ceil_r    = 16'd2000;
        angle_step_r    = 12'd16;
        gain_r          = '0;
        slew_angle      = ANG_90_C;
        build_sine_rom();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_for_results();
                case (p)
                    1: settings = '{1500, 0, 65535, 2880, 65536};
                    2: settings = '{65535, 0, 65535, 0, 131071};
                    3: settings = '{30000, 65535, 0, 4095, 0};
                    4: settings = '{0, 0, 65535, 1, 1};
                    5: settings = '{1500, 1000, 2000, 2880, 32768};
                    default: settings = '{$urandom_range(65535), $urandom_range(65535),
                                          $urandom_range(65535), $urandom_range(4095),
                                          $urandom_range(131071)};
                endcase
                for (int i = 0; i < 5; i++) begin
                    program_reg(vta_reg_t'(i), settings[i]);
                end
            end
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1: begin
                    sender_idle_pct = 72;
                    stall_pct       = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct       = 72;
                end
                default: begin
                    sender_idle_pct = 38;
                    stall_pct       = 38;
                end
            endcase
            if (p == 0) begin
                foreach (directed_rows[i]) begin
                    send_thrust_cmd(directed_rows[i].cmd, directed_rows[i].target,
                                    directed_rows[i].pid, directed_rows[i].known,
                                    directed_rows[i].result);
                end
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off, then a full drain
                if (n == ITEMS_PER_PHASE / 2) begin
                    hold_request = HOLD_CYCLES;
                end
                if (n == 3 * ITEMS_PER_PHASE / 4) begin
                    s_valid <= 1'b0;
                    wait_for_results();
                end
                send_random_cmd();
            end
            s_valid <= 1'b0;
        end
        wait_for_results();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // receiver: scoring and backpressure
    initial begin
        thrust_result_t want;
        int             hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pulse_queue.size() == 0) begin
                    $error("unexpected transaction: left %0d right %0d angle %0d",
                           m_thrust_l, m_thrust_r, m_applied_angle);
                    error_count++;
                end else begin
                    want = pulse_queue.pop_front();
                    if (m_thrust_l !== want.left) begin
                        $error("thrust_l expected %0d actual %0d", want.left, m_thrust_l);
                        error_count++;
                    end
                    if (m_thrust_r !== want.right) begin
                        $error("thrust_r expected %0d actual %0d", want.right, m_thrust_r);
                        error_count++;
                    end
                    if (m_applied_angle !== want.angle) begin
                        $error("applied_angle expected %0d actual %0d",
                               want.angle, m_applied_angle);
                        error_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
